[rtl/ntwa_pkg.sv]
// ---------------------------------------------------------------------------
// ntwa_pkg
// Shared types and constants for the node name table with aging.
// ---------------------------------------------------------------------------
package ntwa_pkg;

   localparam int NAME_BITS = 160;
   localparam int AGE_BITS  = 16;
   localparam int ADDR_BITS = 8;

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_FIND   = 3'd2,
      CMD_LOOKUP = 3'd3,
      CMD_TICK   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REJECTED = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   localparam logic [1:0] CSR_DEAD_AGE = 2'd0;
   localparam logic [1:0] CSR_MIN_ADDR = 2'd1;
   localparam logic [1:0] CSR_MAX_ADDR = 2'd2;

   // Result fields handed from the sequencer to the output register.
   typedef struct packed {
      logic                 strobe;
      logic [1:0]           status;
      logic [ADDR_BITS-1:0] address;
      logic [NAME_BITS-1:0] name;
      logic                 expired;
   } rsp_type;

endpackage

[rtl/node_name_table_with_aging.sv]
// Add, remove, lookup: S_PREP, S_READ and S_DONE, then the result register.
// Name search and tick: S_PREP, S_SCAN over all entries, S_DONE; one entry read
// per cycle from the table memory, each write in the cycle after its read.
// One transaction at a time; busy is high until the result strobe.
// Synchronous reset clears valid bits, config, sequencer and result registers;
// name and age memories hold no reset and are read only for valid entries.
// ---------------------------------------------------------------------------
// node_name_table_with_aging
// Address-indexed name table with heartbeat aging, held in block memories.
// ---------------------------------------------------------------------------
module node_name_table_with_aging #(
   parameter int ENTRIES    = 256,
   parameter int NAME_CHARS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_address,
   input  logic [63:0] req_name_a,
   input  logic [63:0] req_name_b,
   input  logic [31:0] req_name_c,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_found_address,
   output logic [63:0] rsp_found_name_a,
   output logic [63:0] rsp_found_name_b,
   output logic [31:0] rsp_found_name_c,
   output logic        rsp_expired,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import ntwa_pkg::*;

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_READ, S_SCAN, S_DONE
   } state_type;

   // Configuration.
   logic [15:0] dead_age_ff;
   logic [7:0]  min_addr_ff;
   logic [7:0]  max_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_age_ff <= 16'd110;
         min_addr_ff <= 8'd9;
         max_addr_ff <= 8'd245;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEAD_AGE: dead_age_ff <= csr_data;
            CSR_MIN_ADDR: min_addr_ff <= csr_data[7:0];
            CSR_MAX_ADDR: max_addr_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Request capture.
   logic [2:0]           cmd_ff;
   logic [7:0]           addr_ff;
   logic [NAME_BITS-1:0] name;
   logic                 accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         addr_ff <= req_address;
      end
   end

   ntwa_normalize #(.NAME_CHARS(NAME_CHARS)) u_norm (
      .clock     (clock),
      .load      (accept),
      .raw_name  ({req_name_a, req_name_b, req_name_c}),
      .norm_name (name)
   );

   // Memories: valid bits in flops, name and age in registered-read arrays.
   logic [ENTRIES-1:0]   valid_ff;
   logic [NAME_BITS-1:0] name_mem [ENTRIES];
   logic [AGE_BITS-1:0]  age_mem  [ENTRIES];
   logic [NAME_BITS-1:0] name_rd_ff;
   logic [AGE_BITS-1:0]  age_rd_ff;
   logic                 vld_rd_ff;

   logic [IDX_BITS-1:0]  rd_idx;
   logic                 name_we;
   logic                 age_we;
   logic [IDX_BITS-1:0]  wr_idx;
   logic [AGE_BITS-1:0]  age_wd;

   always_ff @(posedge clock) begin
      name_rd_ff <= name_mem[rd_idx];
      age_rd_ff  <= age_mem[rd_idx];
      if (name_we) begin
         name_mem[wr_idx] <= name;
      end
      if (age_we) begin
         age_mem[wr_idx] <= age_wd;
      end
   end

   always_ff @(posedge clock) begin
      vld_rd_ff <= valid_ff[rd_idx];
   end

   // Sequencer.
   state_type            state_ff;
   logic [CNT_BITS-1:0]  cnt_ff;      // read pointer
   logic [IDX_BITS-1:0]  cmp_idx_ff;  // index of data in read registers
   logic                 cmp_ok_ff;
   logic                 hit_ff;
   logic [7:0]           hit_addr_ff;
   logic                 exp_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 addr_in_tab;
   logic                 addr_ok;

   assign addr_in_tab = ({8'd0, addr_ff} < 16'(ENTRIES));
   assign addr_ok     = addr_in_tab && (addr_ff >= min_addr_ff) && (addr_ff <= max_addr_ff);
   assign rd_idx      = (state_ff == S_SCAN) ? cnt_ff[IDX_BITS-1:0] : addr_ff[IDX_BITS-1:0];

   // Write path: add writes at S_PREP; tick writes the age of the compared entry.
   always_comb begin
      name_we = 1'b0;
      age_we  = 1'b0;
      wr_idx  = addr_ff[IDX_BITS-1:0];
      age_wd  = '0;
      if (state_ff == S_PREP && cmd_ff == CMD_ADD && addr_ok) begin
         name_we = 1'b1;
         age_we  = 1'b1;
      end else if (state_ff == S_SCAN && cmd_ff == CMD_TICK && cmp_ok_ff && vld_rd_ff
                   && age_rd_ff < dead_age_ff) begin
         age_we = 1'b1;
         wr_idx = cmp_idx_ff;
         age_wd = age_rd_ff + 16'd1;
      end
   end

   // Result fields, registered when the sequencer leaves S_DONE.
   always_comb begin
      rsp_in = '0;
      if (state_ff == S_DONE) begin
         rsp_in.strobe = 1'b1;
         rsp_in.status = ST_OK;
         case (cmd_ff)
            CMD_ADD: begin
               if (!addr_ok) rsp_in.status = ST_REJECTED;
            end
            CMD_REMOVE: begin
               if (!(addr_in_tab && vld_rd_ff)) rsp_in.status = ST_NOTFOUND;
            end
            CMD_FIND: begin
               if (hit_ff) rsp_in.address = hit_addr_ff;
               else        rsp_in.status  = ST_NOTFOUND;
            end
            CMD_LOOKUP: begin
               if (addr_in_tab && vld_rd_ff) rsp_in.name   = name_rd_ff;
               else                          rsp_in.status = ST_NOTFOUND;
            end
            CMD_TICK: rsp_in.expired = exp_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         rsp_ff     <= '0;
         cnt_ff     <= '0;
         cmp_ok_ff  <= 1'b0;
         hit_ff     <= 1'b0;
         exp_ff     <= 1'b0;
         cmp_idx_ff <= '0;
         hit_addr_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               cnt_ff    <= '0;
               cmp_ok_ff <= 1'b0;
               hit_ff    <= 1'b0;
               exp_ff    <= 1'b0;
               if (cmd_ff == CMD_ADD && addr_ok) begin
                  valid_ff[addr_ff[IDX_BITS-1:0]] <= (name[NAME_BITS-1 -: 8] != 8'd0);
               end
               if (cmd_ff == CMD_FIND || cmd_ff == CMD_TICK) begin
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               // Read data for addr_ff available next cycle.
               state_ff <= S_DONE;
            end
            S_SCAN: begin
               if (cmp_ok_ff && vld_rd_ff) begin
                  if (cmd_ff == CMD_FIND) begin
                     if (!hit_ff && name_rd_ff == name) begin
                        hit_ff      <= 1'b1;
                        hit_addr_ff <= 8'(cmp_idx_ff);
                     end
                  end else if (age_rd_ff >= dead_age_ff) begin
                     valid_ff[cmp_idx_ff] <= 1'b0;
                     exp_ff               <= 1'b1;
                  end
               end
               if (cnt_ff == CNT_BITS'(ENTRIES)) begin
                  cmp_ok_ff <= 1'b0;
                  state_ff  <= S_DONE;
               end else begin
                  cmp_ok_ff  <= 1'b1;
                  cmp_idx_ff <= cnt_ff[IDX_BITS-1:0];
                  cnt_ff     <= cnt_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (cmd_ff == CMD_REMOVE && addr_in_tab && vld_rd_ff) begin
                  valid_ff[addr_ff[IDX_BITS-1:0]] <= 1'b0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_ff.strobe;
   assign rsp_status        = rsp_ff.status;
   assign rsp_found_address = rsp_ff.address;
   assign rsp_found_name_a  = rsp_ff.name[159:96];
   assign rsp_found_name_b  = rsp_ff.name[95:32];
   assign rsp_found_name_c  = rsp_ff.name[31:0];
   assign rsp_expired       = rsp_ff.expired;

endmodule

[rtl/ntwa_normalize.sv]
// ---------------------------------------------------------------------------
// ntwa_normalize
// Registers an incoming name, cutting it at its first zero character and
// beyond the configured name length.
// ---------------------------------------------------------------------------
module ntwa_normalize #(
   parameter int NAME_CHARS = 20
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [ntwa_pkg::NAME_BITS-1:0] raw_name,
   output logic [ntwa_pkg::NAME_BITS-1:0] norm_name
);
   import ntwa_pkg::*;

   localparam int SLOTS = NAME_BITS / 8;

   logic [NAME_BITS-1:0] norm_ff;
   logic [NAME_BITS-1:0] norm_in;
   logic [SLOTS-1:0]     ended;

   // Slot 0 sits in the top byte; the "ended" chain runs downward.
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         ended[k] = (raw_name[NAME_BITS-1-8*k -: 8] == 8'd0) || (k >= NAME_CHARS);
         if (k > 0) begin
            ended[k] = ended[k] | ended[k-1];
         end
         norm_in[NAME_BITS-1-8*k -: 8] = ended[k] ? 8'd0 : raw_name[NAME_BITS-1-8*k -: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         norm_ff <= norm_in;
      end
   end

   assign norm_name = norm_ff;

endmodule

[rtl/ntwa_checker.sv]
// ---------------------------------------------------------------------------
// ntwa_checker
// Port-level checks of the command handshake and result fields.
// ---------------------------------------------------------------------------
module ntwa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_found_address,
   input logic        rsp_expired
);
   import ntwa_pkg::*;

   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction not busy");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result strobe");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3)) else $error("bad status");

   a_addr_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found_address != 8'd0) |-> (rsp_status == ST_OK && !rsp_expired))
      else $error("address with bad status");

endmodule

bind node_name_table_with_aging ntwa_checker u_ntwa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_found_address (rsp_found_address),
   .rsp_expired       (rsp_expired)
);
